### rtl/core/mexp_pkg.sv
// Shared definitions for the modular exponentiation unit.
// Holds widths, the sequencer state type and the sequencer status struct.
// No dependencies.
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int WIDTH  = 32;
    localparam int CNT_W  = $clog2(WIDTH);
    localparam int IN_W   = ((3 * WIDTH + 7) / 8) * 8;
    localparam int OUT_W  = ((WIDTH + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL_ACC,
        ST_SQUARE,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic ready;
        logic done;
    } seq_status_t;

endpackage

### rtl/core/mexp_modmul.sv
// Bit-serial modular multiplier: (a * b) mod m, one multiplier bit per cycle.
// MSB-first double-and-add with a single conditional subtract after each half step.
// Depends on mexp_pkg.
`timescale 1ns / 1ps

module mexp_modmul
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mexp_pkg::WIDTH-1:0]  op_a,
    input  logic [mexp_pkg::WIDTH-1:0]  op_b,
    input  logic [mexp_pkg::WIDTH-1:0]  modulus,
    output logic                        done,
    output logic [mexp_pkg::WIDTH-1:0]  product
);

    logic                        run_reg, run_next;
    logic                        done_reg, done_next;
    logic [mexp_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [mexp_pkg::WIDTH-1:0]  acc_reg, acc_next;
    logic [mexp_pkg::WIDTH-1:0]  a_reg, a_next;
    logic [mexp_pkg::WIDTH-1:0]  b_reg, b_next;

    logic [mexp_pkg::WIDTH:0]    mod_ext;
    logic [mexp_pkg::WIDTH:0]    dbl;
    logic [mexp_pkg::WIDTH:0]    dbl_red;
    logic [mexp_pkg::WIDTH:0]    addend;
    logic [mexp_pkg::WIDTH:0]    sum;
    logic [mexp_pkg::WIDTH:0]    sum_red;

    // One step: acc = 2*acc mod m, then acc = acc + (bit ? a : 0) mod m
    always_comb
    begin
        mod_ext = {1'b0, modulus};
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
        addend  = b_reg[mexp_pkg::WIDTH-1] ? {1'b0, a_reg} : '0;
        sum     = dbl_red + addend;
        sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (!run_reg && start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            acc_next = '0;
            a_next   = op_a;
            b_next   = op_b;
        end
        else if (run_reg)
        begin
            acc_next = sum_red[mexp_pkg::WIDTH-1:0];
            b_next   = {b_reg[mexp_pkg::WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == mexp_pkg::CNT_W'(mexp_pkg::WIDTH - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### rtl/core/mexp_seq.sv
// Square-and-multiply sequencer around one shared modular multiplier.
// Scans the exponent from its LSB, reducing the base first.
// Depends on mexp_pkg and mexp_modmul.
`timescale 1ns / 1ps

module mexp_seq
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mexp_pkg::WIDTH-1:0]  base_value,
    input  logic [mexp_pkg::WIDTH-1:0]  exponent,
    input  logic [mexp_pkg::WIDTH-1:0]  modulus,
    input  logic                        out_free,
    output mexp_pkg::seq_status_t       status,
    output logic [mexp_pkg::WIDTH-1:0]  power_result,
    output logic                        bad_modulus
);

    mexp_pkg::seq_state_t        state_reg, state_next;
    logic                        issued_reg, issued_next;
    logic                        bad_reg, bad_next;
    logic [mexp_pkg::WIDTH-1:0]  base_reg, base_next;
    logic [mexp_pkg::WIDTH-1:0]  exp_reg, exp_next;
    logic [mexp_pkg::WIDTH-1:0]  mod_reg, mod_next;
    logic [mexp_pkg::WIDTH-1:0]  acc_reg, acc_next;

    logic                        mul_start;
    logic [mexp_pkg::WIDTH-1:0]  mul_a;
    logic [mexp_pkg::WIDTH-1:0]  mul_b;
    logic                        mul_done;
    logic [mexp_pkg::WIDTH-1:0]  mul_res;
    logic [mexp_pkg::WIDTH-1:0]  exp_shr;

    localparam logic [mexp_pkg::WIDTH-1:0] ONE = mexp_pkg::WIDTH'(1);

    mexp_modmul u_modmul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .modulus (mod_reg),
        .done    (mul_done),
        .product (mul_res)
    );

    assign exp_shr = {1'b0, exp_reg[mexp_pkg::WIDTH-1:1]};

    // Next state and datapath registers
    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        bad_next    = bad_reg;
        base_next   = base_reg;
        exp_next    = exp_reg;
        mod_next    = mod_reg;
        acc_next    = acc_reg;
        if (mul_start)
            issued_next = 1'b1;
        unique case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    base_next = base_value;
                    exp_next  = exponent;
                    mod_next  = modulus;
                    acc_next  = ONE;
                    bad_next  = (modulus == '0);
                    if (modulus == '0)
                    begin
                        acc_next   = '0;
                        state_next = mexp_pkg::ST_FINISH;
                    end
                    else
                        state_next = mexp_pkg::ST_REDUCE;
                end
            end
            mexp_pkg::ST_REDUCE:
            begin
                if (mul_done)
                begin
                    issued_next = 1'b0;
                    base_next   = mul_res;
                    if (exp_reg == '0)
                        state_next = mexp_pkg::ST_FINISH;
                    else if (exp_reg[0])
                        state_next = mexp_pkg::ST_MUL_ACC;
                    else
                        state_next = mexp_pkg::ST_SQUARE;
                end
            end
            mexp_pkg::ST_MUL_ACC:
            begin
                if (mul_done)
                begin
                    issued_next = 1'b0;
                    acc_next    = mul_res;
                    // skip the trailing square once no set bit remains
                    if (exp_shr == '0)
                        state_next = mexp_pkg::ST_FINISH;
                    else
                        state_next = mexp_pkg::ST_SQUARE;
                end
            end
            mexp_pkg::ST_SQUARE:
            begin
                if (mul_done)
                begin
                    issued_next = 1'b0;
                    base_next   = mul_res;
                    exp_next    = exp_shr;
                    if (exp_shr[0])
                        state_next = mexp_pkg::ST_MUL_ACC;
                    else
                        state_next = mexp_pkg::ST_SQUARE;
                end
            end
            mexp_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = mexp_pkg::ST_IDLE;
            end
            default:
                state_next = mexp_pkg::ST_IDLE;
        endcase
    end

    // Outputs: operand select, multiplier launch and status
    always_comb
    begin
        mul_start     = 1'b0;
        mul_a         = base_reg;
        mul_b         = base_reg;
        status.ready  = 1'b0;
        status.done   = 1'b0;
        unique case (state_reg)
            mexp_pkg::ST_IDLE:
                status.ready = 1'b1;
            mexp_pkg::ST_REDUCE:
            begin
                mul_start = !issued_reg;
                mul_a     = ONE;
            end
            mexp_pkg::ST_MUL_ACC:
            begin
                mul_start = !issued_reg;
                mul_a     = acc_reg;
            end
            mexp_pkg::ST_SQUARE:
                mul_start = !issued_reg;
            mexp_pkg::ST_FINISH:
                status.done = 1'b1;
            default:
                status.ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mexp_pkg::ST_IDLE;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bad_reg  <= bad_next;
        base_reg <= base_next;
        exp_reg  <= exp_next;
        mod_reg  <= mod_next;
        acc_reg  <= acc_next;
    end

    assign power_result = acc_reg;
    assign bad_modulus  = bad_reg;

endmodule

### rtl/core/modular_exponentiation_unit.sv
// Top level of the modular exponentiation unit: stream ports and result register.
// Depends on mexp_pkg and mexp_seq.
//
// Computes base^exponent mod modulus by right-to-left binary square-and-multiply.
// One request is taken at a time; s_axis_tready is high only while the sequencer
// is idle, but a finished result may still wait in the output register. Each
// modular multiplication runs on one shared bit-serial unit. A request costs one
// reduction of the base plus, per exponent bit up to the highest set one, one
// square (not after the top bit) and one multiply for each set bit. A zero modulus
// returns at once with bad_modulus set and a result of 0; a zero exponent gives 1.
`timescale 1ns / 1ps

module modular_exponentiation_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // base_value, exponent, modulus (from bit 0 up)
    input  logic [mexp_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // power_result (from bit 0 up)
    output logic [mexp_pkg::OUT_W-1:0]  m_axis_tdata,
    // bad_modulus
    output logic                        m_axis_tuser
);

    localparam int W = mexp_pkg::WIDTH;

    mexp_pkg::seq_status_t  status;
    logic                   start;
    logic                   out_free;
    logic                   load;
    logic [W-1:0]           seq_result;
    logic                   seq_bad;

    logic                   out_valid_reg, out_valid_next;
    logic [W-1:0]           out_data_reg, out_data_next;
    logic                   out_bad_reg, out_bad_next;

    assign start    = s_axis_tvalid && status.ready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign load     = status.done && out_free;

    mexp_seq u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .base_value   (s_axis_tdata[W-1:0]),
        .exponent     (s_axis_tdata[2*W-1:W]),
        .modulus      (s_axis_tdata[3*W-1:2*W]),
        .out_free     (out_free),
        .status       (status),
        .power_result (seq_result),
        .bad_modulus  (seq_bad)
    );

    // Hold the result until the downstream side takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_bad_next   = out_bad_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = seq_result;
            out_bad_next   = seq_bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_bad_reg  <= out_bad_next;
    end

    assign s_axis_tready = status.ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = mexp_pkg::OUT_W'(out_data_reg);
    assign m_axis_tuser  = out_bad_reg;

endmodule

### dv/modular_exponentiation_checker.sv
// Checker for the modular exponentiation unit: watches both stream channels,
// predicts each result from the accepted request and compares it field by field.
// Depends on mexp_pkg.
`timescale 1ns / 1ps

module modular_exponentiation_checker
    import mexp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    // base_value, exponent, modulus (from bit 0 up)
    input  logic [IN_W-1:0]   s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    // power_result (from bit 0 up)
    input  logic [OUT_W-1:0]  m_tdata,
    // bad_modulus
    input  logic              m_tuser,
    output int                mismatches,
    output int                outstanding
);

    typedef struct packed {
        logic [WIDTH-1:0] power;
        logic             bad;
    } power_item_t;

    power_item_t expected_powers[$];

    function automatic power_item_t predict_power(logic [WIDTH-1:0] base_in,
                                                  logic [WIDTH-1:0] exp_in,
                                                  logic [WIDTH-1:0] mod_in);
        power_item_t          r;
        logic [2*WIDTH-1:0]   acc;
        logic [2*WIDTH-1:0]   run;
        logic [2*WIDTH-1:0]   modw;
        logic [WIDTH-1:0]     e;
        r.power = '0;
        r.bad   = 1'b0;
        if (mod_in == '0) begin
            r.bad = 1'b1;
            return r;
        end
        modw = {{WIDTH{1'b0}}, mod_in};
        // Start from 1 unreduced, so a zero exponent gives 1 even for modulus one
        acc  = 1;
        run  = {{WIDTH{1'b0}}, base_in} % modw;
        e    = exp_in;
        while (e != '0) begin
            if (e[0])
                acc = (acc * run) % modw;
            run = (run * run) % modw;
            e   = e >> 1;
        end
        r.power = acc[WIDTH-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        int          errs;
        power_item_t want;
        errs = 0;
        if (!rst_n) begin
            expected_powers.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else begin
            // Compare results before taking the new request of the same edge
            if (m_tvalid && m_tready) begin
                if (expected_powers.size() == 0) begin
                    $display("%0t: unexpected result: power_result=%h bad_modulus=%b",
                             $time, m_tdata[WIDTH-1:0], m_tuser);
                    errs++;
                end
                else begin
                    want = expected_powers.pop_front();
                    if (m_tdata[WIDTH-1:0] !== want.power) begin
                        $display("%0t: power_result mismatch: expected %h, actual %h",
                                 $time, want.power, m_tdata[WIDTH-1:0]);
                        errs++;
                    end
                    if (m_tuser !== want.bad) begin
                        $display("%0t: bad_modulus mismatch: expected %b, actual %b",
                                 $time, want.bad, m_tuser);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_powers.push_back(predict_power(s_tdata[WIDTH-1:0],
                                                        s_tdata[2*WIDTH-1:WIDTH],
                                                        s_tdata[3*WIDTH-1:2*WIDTH]));
            mismatches  <= mismatches + errs;
            outstanding <= expected_powers.size();
        end
    end

endmodule

### dv/modular_exponentiation_unit_test.sv
// Testbench top for the modular exponentiation unit: clock, reset, request
// stimulus with random gaps, result back-pressure and the final verdict.
// Depends on mexp_pkg, modular_exponentiation_unit and modular_exponentiation_checker.
`timescale 1ns / 1ps

module modular_exponentiation_unit_test;
    import mexp_pkg::*;

    localparam logic [WIDTH-1:0] ALL_ONES = {WIDTH{1'b1}};
    localparam int RANDOM_REQUESTS = 255;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tuser;

    int mismatches;
    int outstanding;
    int ready_hold;
    bit no_idle;

    always #5 clk = ~clk;

    modular_exponentiation_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    modular_exponentiation_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .m_tuser     (m_axis_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Mostly short spans, some medium, a few long
    function automatic int pick_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 3);
        if (r < 95)
            return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    // Result back-pressure: hold tready at a random level for a random span, or high while no_idle is set
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            ready_hold    <= 0;
        end
        else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end
        else begin
            ready_hold    <= no_idle ? 0 : pick_span();
            m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    task automatic send_request(input logic [WIDTH-1:0] base_in,
                                input logic [WIDTH-1:0] exp_in,
                                input logic [WIDTH-1:0] mod_in);
        logic [IN_W-1:0] word;
        int              gap;
        word = '0;
        word[WIDTH-1:0]         = base_in;
        word[2*WIDTH-1:WIDTH]   = exp_in;
        word[3*WIDTH-1:2*WIDTH] = mod_in;
        s_axis_tdata  <= word;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        gap = no_idle ? 0 : pick_span();
        // Keep valid high into the next request when there is no gap
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_request();
        logic [WIDTH-1:0] b;
        logic [WIDTH-1:0] e;
        logic [WIDTH-1:0] m;
        int               kind;
        b    = $urandom();
        e    = $urandom();
        m    = $urandom();
        kind = $urandom_range(0, 99);
        if (kind < 8)
            m = '0;
        else if (kind < 14)
            m = 1;
        else if (kind < 30)
            m = $urandom_range(2, 255);
        else if (kind < 38)
            m = ALL_ONES - $urandom_range(0, 15);
        kind = $urandom_range(0, 99);
        if (kind < 10)
            e = '0;
        else if (kind < 30)
            e = $urandom_range(1, 15);
        else if (kind < 40)
            e = e | (1 << (WIDTH - 1));
        kind = $urandom_range(0, 99);
        if (kind < 8)
            b = '0;
        else if (kind < 14 && m != '0)
            b = m * $urandom_range(1, 3);
        send_request(b, e, m);
    endtask

    initial begin
        no_idle = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero modulus, with small and full-scale operands
        send_request('0, '0, '0);
        send_request(ALL_ONES, ALL_ONES, '0);
        send_request(32'h1234_5678, 32'h0000_0003, '0);
        // Zero exponent, modulus one included
        send_request(5, '0, 1);
        send_request('0, '0, 7);
        send_request(ALL_ONES, '0, ALL_ONES);
        // Modulus one with nonzero exponent
        send_request(7, 5, 1);
        send_request(ALL_ONES, ALL_ONES, 1);
        // Extremes of every field
        send_request(ALL_ONES, ALL_ONES, ALL_ONES);
        send_request(ALL_ONES, 1, ALL_ONES - 1);
        send_request(3, ALL_ONES, ALL_ONES - 4);
        send_request(1, ALL_ONES, ALL_ONES);
        send_request('0, 5, 13);
        send_request(2, 32'h8000_0000, ALL_ONES);
        // Base above or equal to the modulus, then two with the base below it
        send_request(100, 3, 7);
        send_request(13, 3, 13);
        send_request(ALL_ONES, 32'hAAAA_5555, 2);
        send_request(2, 10, 1000);
        send_request(32'hDEAD_BEEF, 32'h5555_AAAA, 32'hFFFF_FFFB);

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            // Switch now and then to a stretch with no idling on either side
            if (i % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_random_request();
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (2500) @(posedge clk);

        if (mismatches == 0)
            $display("** modular_exponentiation_unit: PASSED **");
        else
            $display("** modular_exponentiation_unit: FAILED **");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("** modular_exponentiation_unit: FAILED **");
        $finish;
    end

endmodule
